// ===== sv/sapd_pkg.sv =====
// ----------------------------------------------------------------------------
// sapd_pkg
// Shared types, codes and the byte-to-symbol mapping for the suffix array
// builder.
// ----------------------------------------------------------------------------
package sapd_pkg;

    localparam int CODE_W    = 3;
    localparam int NUM_CODES = 5;
    localparam int STAT_W    = 2;
    localparam int RANK_W    = 10;
    localparam int SYM_W     = 8;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_READ = 2'd2;

    localparam logic [SYM_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [SYM_W-1:0] CH_A      = 8'h41;
    localparam logic [SYM_W-1:0] CH_C      = 8'h43;
    localparam logic [SYM_W-1:0] CH_G      = 8'h47;

    localparam logic [CODE_W-1:0] CODE_DOLLAR = 3'd0;
    localparam logic [CODE_W-1:0] CODE_A      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_C      = 3'd2;
    localparam logic [CODE_W-1:0] CODE_G      = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OTHER  = 3'd4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ
    } sapd_top_state_t;

    typedef enum logic [4:0] {
        C_IDLE,
        C_CLR,
        C_CNT_A,
        C_CNT_B,
        C_CNT_C,
        C_PRE_A,
        C_PRE_B,
        C_PL_A,
        C_PL_B,
        C_PL_C,
        C_PL_D,
        C_PL_E,
        C_CL_A,
        C_CL_B,
        C_CL_C,
        C_CL_D,
        C_CL_E,
        C_NEXT
    } sapd_core_state_t;

    typedef struct packed {
        logic load_we;
        logic build;
    } sapd_ctl_t;

    function automatic logic [CODE_W-1:0] code_of_byte(input logic [SYM_W-1:0] b);
        logic [CODE_W-1:0] c;
        case (b)
            CH_DOLLAR: c = CODE_DOLLAR;
            CH_A:      c = CODE_A;
            CH_C:      c = CODE_C;
            CH_G:      c = CODE_G;
            default:   c = CODE_OTHER;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/sapd_modadd.sv =====
// ----------------------------------------------------------------------------
// sapd_modadd
// Shared cyclic position adder: (a + b) mod n for a, b below n.
// ----------------------------------------------------------------------------
module sapd_modadd import sapd_pkg::*; #(
    parameter int AW = 10,
    parameter int LW = 11
) (
    input  logic [AW-1:0] a,
    input  logic [LW-1:0] b,
    input  logic [LW-1:0] n,
    output logic [AW-1:0] y
);

    logic [LW:0] sum;
    logic [LW:0] red;

    // Both operands stay below n, so one conditional subtract wraps the sum.
    always_comb begin
        sum = (LW+1)'(a) + (LW+1)'(b);
        red = sum;
        if (sum >= (LW+1)'(n)) begin
            red = sum - (LW+1)'(n);
        end
        y = red[AW-1:0];
    end

endmodule

// ===== sv/sapd_core.sv =====
// ----------------------------------------------------------------------------
// sapd_core
// Text, order, class and bucket memories with the prefix doubling sequencer.
// ----------------------------------------------------------------------------
module sapd_core import sapd_pkg::*; #(
    parameter int MAX_LEN = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sapd_ctl_t                    ctl,
    input  logic [$clog2(MAX_LEN)-1:0]   load_addr,
    input  logic [CODE_W-1:0]            load_code,
    input  logic [$clog2(MAX_LEN)-1:0]   rd_addr,
    input  logic [$clog2(MAX_LEN):0]     n_len,
    output logic                         busy,
    output logic [$clog2(MAX_LEN)-1:0]   rd_data
);

    localparam int AW   = $clog2(MAX_LEN);
    localparam int LW   = AW + 1;
    localparam int BD   = (MAX_LEN < 8) ? 8 : MAX_LEN;
    localparam int KW   = $clog2(BD);
    localparam int CNTW = KW + 1;

    logic [CODE_W-1:0] codes_mem [MAX_LEN];
    logic [AW-1:0]     ord0_mem  [MAX_LEN];
    logic [AW-1:0]     ord1_mem  [MAX_LEN];
    logic [AW-1:0]     cls0_mem  [MAX_LEN];
    logic [AW-1:0]     cls1_mem  [MAX_LEN];
    logic [LW-1:0]     bkt_mem   [BD];

    logic [CODE_W-1:0] codes_rd_reg;
    logic [AW-1:0]     ord0_rd_reg, ord1_rd_reg, cls0_rd_reg, cls1_rd_reg;
    logic [LW-1:0]     bkt_rd_reg;

    logic              codes_we;
    logic [AW-1:0]     codes_wa;
    logic [CODE_W-1:0] codes_wd;
    logic [AW-1:0]     key_ra, ord_ra, ord_wa, ord_wd, cls_wa, cls_wd;
    logic              ord_we, cls_we, bkt_we;
    logic [KW-1:0]     bkt_ra, bkt_wa;
    logic [LW-1:0]     bkt_wd;

    sapd_core_state_t  state_reg, state_next;
    logic [CNTW-1:0]   i_reg, i_next;
    logic [LW-1:0]     len_reg, len_next, l_reg, l_next, nl_reg, nl_next;
    logic [LW-1:0]     acc_reg, acc_next;
    logic [KW-1:0]     key_reg, key_next, k1_reg, k1_next;
    logic [KW-1:0]     pk1_reg, pk1_next, pk2_reg, pk2_next;
    logic [AW-1:0]     p_reg, p_next, cur_reg, cur_next, cur2_reg, cur2_next;
    logic [AW-1:0]     cacc_reg, cacc_next;
    logic              osel_reg, osel_next, csel_reg, csel_next;
    logic              single_reg, single_next;

    logic [KW-1:0]     key_rd;
    logic [AW-1:0]     ord_rd;
    logic [CNTW-1:0]   kmax, i_inc, i_dec;
    logic [AW-1:0]     ma_y;
    logic [LW-1:0]     ma_b;
    logic [LW-1:0]     bkt_dec;
    logic [AW-1:0]     cls_new;
    logic              differ;

    assign key_rd  = single_reg ? KW'(codes_rd_reg) : KW'(csel_reg ? cls1_rd_reg : cls0_rd_reg);
    assign ord_rd  = osel_reg ? ord1_rd_reg : ord0_rd_reg;
    assign rd_data = ord_rd;
    assign busy    = (state_reg != C_IDLE);
    assign kmax    = single_reg ? CNTW'(NUM_CODES) : CNTW'(len_reg);
    assign i_inc   = i_reg + CNTW'(1);
    assign i_dec   = i_reg - CNTW'(1);
    assign bkt_dec = bkt_rd_reg - LW'(1);
    assign ma_b    = (state_reg == C_PL_B) ? nl_reg : l_reg;

    sapd_modadd #(.AW(AW), .LW(LW)) u_modadd (
        .a (ord_rd),
        .b (ma_b),
        .n (len_reg),
        .y (ma_y)
    );

    // Memories: one write and one registered read each cycle.
    always_ff @(posedge aclk) begin
        if (codes_we) begin
            codes_mem[codes_wa] <= codes_wd;
        end
        codes_rd_reg <= codes_mem[key_ra];
    end

    always_ff @(posedge aclk) begin
        if (ord_we && !osel_reg) begin
            ord1_mem[ord_wa] <= ord_wd;
        end
        if (ord_we && osel_reg) begin
            ord0_mem[ord_wa] <= ord_wd;
        end
        ord0_rd_reg <= ord0_mem[ord_ra];
        ord1_rd_reg <= ord1_mem[ord_ra];
    end

    always_ff @(posedge aclk) begin
        if (cls_we && !csel_reg) begin
            cls1_mem[cls_wa] <= cls_wd;
        end
        if (cls_we && csel_reg) begin
            cls0_mem[cls_wa] <= cls_wd;
        end
        cls0_rd_reg <= cls0_mem[key_ra];
        cls1_rd_reg <= cls1_mem[key_ra];
    end

    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        bkt_rd_reg <= bkt_mem[bkt_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= C_IDLE;
            osel_reg   <= 1'b0;
            csel_reg   <= 1'b0;
            single_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            osel_reg   <= osel_next;
            csel_reg   <= csel_next;
            single_reg <= single_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        len_reg  <= len_next;
        l_reg    <= l_next;
        nl_reg   <= nl_next;
        acc_reg  <= acc_next;
        key_reg  <= key_next;
        k1_reg   <= k1_next;
        pk1_reg  <= pk1_next;
        pk2_reg  <= pk2_next;
        p_reg    <= p_next;
        cur_reg  <= cur_next;
        cur2_reg <= cur2_next;
        cacc_reg <= cacc_next;
    end

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        len_next    = len_reg;
        l_next      = l_reg;
        nl_next     = nl_reg;
        acc_next    = acc_reg;
        key_next    = key_reg;
        k1_next     = k1_reg;
        pk1_next    = pk1_reg;
        pk2_next    = pk2_reg;
        p_next      = p_reg;
        cur_next    = cur_reg;
        cur2_next   = cur2_reg;
        cacc_next   = cacc_reg;
        osel_next   = osel_reg;
        csel_next   = csel_reg;
        single_next = single_reg;

        codes_we = 1'b0;
        codes_wa = load_addr;
        codes_wd = load_code;
        key_ra   = i_reg[AW-1:0];
        ord_ra   = i_reg[AW-1:0];
        ord_we   = 1'b0;
        ord_wa   = bkt_dec[AW-1:0];
        ord_wd   = p_reg;
        cls_we   = 1'b0;
        cls_wa   = cur_reg;
        bkt_we   = 1'b0;
        bkt_ra   = key_rd;
        bkt_wa   = key_reg;
        bkt_wd   = bkt_rd_reg + LW'(1);

        differ  = (i_reg != '0) &&
                  ((k1_reg != pk1_reg) || (!single_reg && (key_rd != pk2_reg)));
        // The smallest shift of each pass opens class zero.
        cls_new = (i_reg == '0) ? '0 : cacc_reg + AW'(differ);
        cls_wd  = cls_new;

        case (state_reg)
            C_IDLE: begin
                ord_ra   = rd_addr;
                codes_we = ctl.load_we;
                if (ctl.build) begin
                    len_next    = n_len;
                    l_next      = LW'(1);
                    single_next = 1'b1;
                    i_next      = '0;
                    state_next  = C_CLR;
                end
            end
            C_CLR: begin
                bkt_we  = 1'b1;
                bkt_wa  = i_reg[KW-1:0];
                bkt_wd  = '0;
                nl_next = len_reg - l_reg;
                i_next  = i_inc;
                if (i_inc == kmax) begin
                    i_next     = '0;
                    state_next = C_CNT_A;
                end
            end
            C_CNT_A: begin
                state_next = C_CNT_B;
            end
            C_CNT_B: begin
                key_next   = key_rd;
                state_next = C_CNT_C;
            end
            C_CNT_C: begin
                bkt_we = 1'b1;
                i_next = i_inc;
                if (i_inc == CNTW'(len_reg)) begin
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = C_PRE_A;
                end else begin
                    state_next = C_CNT_A;
                end
            end
            C_PRE_A: begin
                bkt_ra     = i_reg[KW-1:0];
                state_next = C_PRE_B;
            end
            C_PRE_B: begin
                bkt_we   = 1'b1;
                bkt_wa   = i_reg[KW-1:0];
                bkt_wd   = acc_reg + bkt_rd_reg;
                acc_next = acc_reg + bkt_rd_reg;
                i_next   = i_inc;
                if (i_inc == kmax) begin
                    i_next     = CNTW'(len_reg);
                    state_next = C_PL_A;
                end else begin
                    state_next = C_PRE_A;
                end
            end
            C_PL_A: begin
                ord_ra     = i_dec[AW-1:0];
                state_next = C_PL_B;
            end
            C_PL_B: begin
                // Single symbols place position i-1; later rounds place the
                // shift that starts L positions before the sorted one.
                p_next     = single_reg ? i_dec[AW-1:0] : ma_y;
                state_next = C_PL_C;
            end
            C_PL_C: begin
                key_ra     = p_reg;
                state_next = C_PL_D;
            end
            C_PL_D: begin
                key_next   = key_rd;
                state_next = C_PL_E;
            end
            C_PL_E: begin
                bkt_we = 1'b1;
                bkt_wd = bkt_dec;
                ord_we = 1'b1;
                i_next = i_dec;
                if (i_reg == CNTW'(1)) begin
                    osel_next  = !osel_reg;
                    i_next     = '0;
                    state_next = C_CL_A;
                end else begin
                    state_next = C_PL_A;
                end
            end
            C_CL_A: begin
                state_next = C_CL_B;
            end
            C_CL_B: begin
                cur_next   = ord_rd;
                cur2_next  = ma_y;
                state_next = C_CL_C;
            end
            C_CL_C: begin
                key_ra     = cur_reg;
                state_next = C_CL_D;
            end
            C_CL_D: begin
                k1_next    = key_rd;
                key_ra     = cur2_reg;
                state_next = C_CL_E;
            end
            C_CL_E: begin
                cls_we    = 1'b1;
                cacc_next = cls_new;
                pk1_next  = k1_reg;
                pk2_next  = key_rd;
                i_next    = i_inc;
                if (i_inc == CNTW'(len_reg)) begin
                    csel_next   = !csel_reg;
                    single_next = 1'b0;
                    if (!single_reg) begin
                        l_next = l_reg << 1;
                    end
                    state_next = C_NEXT;
                end else begin
                    state_next = C_CL_A;
                end
            end
            C_NEXT: begin
                i_next = '0;
                if (l_reg < len_reg) begin
                    state_next = C_CLR;
                end else begin
                    state_next = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/suffix_array_prefix_doubling.sv =====
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling
// Loads a DNA text, builds its cyclic-shift order by prefix doubling with
// counting sorts, and answers rank lookups.
// ----------------------------------------------------------------------------
// Channel | Ports                    | Contents
// input   | s_tvalid/s_tready        | tdata: symbol, read_index; tuser: action;
//         |                          | tlast: last
// result  | m_tvalid/m_tready        | tdata: suffix_start; tuser: status
//
// A load is answered from a registered result; a read goes through a
// registered memory lookup and the T_READ state. A load flagged last starts
// construction: each round is a counting sort and a class pass over the
// positions, for ceil(log2 n)+1 rounds; s_tready stays low meanwhile. Reset
// is synchronous; the memories are not cleared. A stalled result holds the
// next item off until it is taken.
// ----------------------------------------------------------------------------
module suffix_array_prefix_doubling import sapd_pkg::*; #(
    parameter int MAX_LEN = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] symbol, [17:8] read_index, zero pad
    input  logic [0:0]  s_tuser,   // [0] action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] suffix_start, zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW   = $clog2(MAX_LEN);
    localparam int LW   = AW + 1;
    localparam int CMPW = (LW > RANK_W) ? LW : RANK_W;

    sapd_top_state_t   state_reg, state_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [RANK_W-1:0] start_reg, start_next;
    logic [LW-1:0]     len_reg, len_next;
    logic              built_reg, built_next;
    logic              rd_ok_reg, rd_ok_next;

    sapd_ctl_t         ctl;
    logic              core_busy;
    logic [AW-1:0]     core_rd_data;
    logic              accept;
    logic [SYM_W-1:0]  symbol;
    logic [RANK_W-1:0] rank;
    logic [LW-1:0]     eff_len;
    logic              full;

    assign symbol  = s_tdata[7:0];
    assign rank    = s_tdata[17:8];
    assign s_tready = (state_reg == T_IDLE) && !core_busy && (!m_tvalid_reg || m_tready);
    assign accept  = s_tvalid && s_tready;
    // The first load after a build starts a fresh text.
    assign eff_len = built_reg ? '0 : len_reg;
    assign full    = (eff_len == LW'(MAX_LEN));

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, start_reg};

    always_comb begin
        ctl.load_we = accept && (s_tuser[0] == ACT_LOAD) && !full;
        ctl.build   = accept && (s_tuser[0] == ACT_LOAD) && s_tlast;
    end

    sapd_core #(.MAX_LEN(MAX_LEN)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .load_addr (eff_len[AW-1:0]),
        .load_code (code_of_byte(symbol)),
        .rd_addr   (AW'(rank)),
        .n_len     (full ? eff_len : eff_len + LW'(1)),
        .busy      (core_busy),
        .rd_data   (core_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            m_tvalid_reg <= 1'b0;
            len_reg      <= '0;
            built_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            len_reg      <= len_next;
            built_reg    <= built_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        start_reg  <= start_next;
        rd_ok_reg  <= rd_ok_next;
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        status_next   = status_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        built_next    = built_reg;
        rd_ok_next    = rd_ok_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == ACT_LOAD) begin
                        m_tvalid_next = 1'b1;
                        start_next    = '0;
                        status_next   = full ? ST_DROPPED : ST_OK;
                        len_next      = full ? eff_len : eff_len + LW'(1);
                        // Reads stay blocked until the build finishes.
                        built_next    = s_tlast;
                    end else begin
                        rd_ok_next = built_reg && (CMPW'(rank) < CMPW'(len_reg));
                        state_next = T_READ;
                    end
                end
            end
            T_READ: begin
                m_tvalid_next = 1'b1;
                status_next   = rd_ok_reg ? ST_OK : ST_BAD_READ;
                start_next    = rd_ok_reg ? RANK_W'(core_rd_data) : '0;
                state_next    = T_IDLE;
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

endmodule

// ===== verif/suffix_array_prefix_doubling_tb.sv =====
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling_tb
// Self-checking bench for the suffix array builder. A directed table covers
// reads before construction, single-symbol and mixed-alphabet texts, rank
// bounds and restarts. Random DNA texts with read bursts, noise reads and
// one store-filling text follow. Results are compared with a prefix-doubling
// predictor kept inside the bench, or with the table's own values for typed rows.
// ----------------------------------------------------------------------------
module suffix_array_prefix_doubling_tb import sapd_pkg::*; ();

    localparam int TEXT_MAX  = 1024;
    localparam int RAND_ITEMS = 100;
    localparam longint CYCLE_LIMIT = 40_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    suffix_array_prefix_doubling #(.MAX_LEN(TEXT_MAX)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Predictor state.
    logic [CODE_W-1:0] pr_codes [TEXT_MAX];
    int pr_order [TEXT_MAX];
    int pr_next_order [TEXT_MAX];
    int pr_class [TEXT_MAX];
    int pr_next_class [TEXT_MAX];
    int pr_count [TEXT_MAX];
    int pr_len;
    bit pr_built;

    logic [1:0] want_status [$];
    logic [9:0] want_start [$];

    int  errors;
    int  results_seen;
    int  builds_done;
    int  snd_idle;
    int  rcv_idle;
    longint cycles;

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    function automatic logic [CODE_W-1:0] sym_code(input logic [7:0] b);
        if (b == CH_DOLLAR) return CODE_DOLLAR;
        if (b == CH_A) return CODE_A;
        if (b == CH_C) return CODE_C;
        if (b == CH_G) return CODE_G;
        return CODE_OTHER;
    endfunction

    function automatic void build_order();
        int n;
        int len_l;
        int i;
        int st;
        int c;
        bit differ;
        n = pr_len;
        if (n == 0) return;
        for (i = 0; i < NUM_CODES; i++) pr_count[i] = 0;
        for (i = 0; i < n; i++) pr_count[pr_codes[i]]++;
        for (i = 1; i < NUM_CODES; i++) pr_count[i] += pr_count[i-1];
        for (i = n - 1; i >= 0; i--) begin
            c = pr_codes[i];
            pr_count[c]--;
            pr_order[pr_count[c]] = i;
        end
        pr_class[pr_order[0]] = 0;
        for (i = 1; i < n; i++)
            pr_class[pr_order[i]] = pr_class[pr_order[i-1]] +
                ((pr_codes[pr_order[i]] != pr_codes[pr_order[i-1]]) ? 1 : 0);
        len_l = 1;
        while (len_l < n) begin
            for (i = 0; i < n; i++) pr_count[i] = 0;
            for (i = 0; i < n; i++) pr_count[pr_class[i]]++;
            for (i = 1; i < n; i++) pr_count[i] += pr_count[i-1];
            for (i = n - 1; i >= 0; i--) begin
                st = (pr_order[i] + n - len_l) % n;
                c = pr_class[st];
                pr_count[c]--;
                pr_next_order[pr_count[c]] = st;
            end
            for (i = 0; i < n; i++) pr_order[i] = pr_next_order[i];
            pr_next_class[pr_order[0]] = 0;
            for (i = 1; i < n; i++) begin
                differ = pr_class[pr_order[i]] != pr_class[pr_order[i-1]] ||
                         pr_class[(pr_order[i] + len_l) % n] !=
                         pr_class[(pr_order[i-1] + len_l) % n];
                pr_next_class[pr_order[i]] = pr_next_class[pr_order[i-1]] +
                    (differ ? 1 : 0);
            end
            for (i = 0; i < n; i++) pr_class[i] = pr_next_class[i];
            len_l = len_l * 2;
        end
        pr_built = 1'b1;
        builds_done++;
    endfunction

    function automatic void predict_item(input logic act, input logic [7:0] sym,
                                         input logic lst, input logic [9:0] idx,
                                         output logic [1:0] st,
                                         output logic [9:0] start);
        st = ST_OK;
        start = '0;
        if (act == ACT_LOAD) begin
            if (pr_built) begin
                pr_built = 1'b0;
                pr_len = 0;
            end
            if (pr_len < TEXT_MAX) begin
                pr_codes[pr_len] = sym_code(sym);
                pr_len++;
            end else begin
                st = ST_DROPPED;
            end
            if (lst) build_order();
        end else if (pr_built && idx < pr_len) begin
            start = pr_order[idx][9:0];
        end else begin
            st = ST_BAD_READ;
        end
    endfunction

    // Drives one item from the falling edge and waits for its acceptance.
    task automatic send_item(input logic act, input logic [7:0] sym, input logic lst,
                             input logic [9:0] idx, input bit typed,
                             input logic [1:0] typed_st, input logic [9:0] typed_start);
        logic [1:0] st;
        logic [9:0] start;
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, idx, sym};
        s_tuser  <= act;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        predict_item(act, sym, lst, idx, st, start);
        if (typed) begin
            st = typed_st;
            start = typed_start;
        end
        want_status.push_back(st);
        want_start.push_back(start);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (want_status.size() == 0) begin
                $display("%0t: unexpected result status=%0d start=%0d",
                         $time, m_tuser, m_tdata[9:0]);
                errors++;
            end else begin
                if (m_tuser !== want_status[0]) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_status[0], m_tuser);
                    errors++;
                end
                if (m_tdata[9:0] !== want_start[0]) begin
                    $display("%0t: suffix_start expected %0d actual %0d",
                             $time, want_start[0], m_tdata[9:0]);
                    errors++;
                end
                void'(want_status.pop_front());
                void'(want_start.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL suffix_array_prefix_doubling");
            $finish;
        end
    end

    typedef struct {
        logic       act;
        logic [7:0] sym;
        logic       lst;
        logic [9:0] idx;
        bit         typed;
        logic [1:0] st;
        logic [9:0] start;
    } stim_row_t;

    stim_row_t rows [] = '{
        '{ACT_READ, 8'hFF, 1'b0, 10'd0,    1, ST_BAD_READ, 10'd0},
        '{ACT_LOAD, CH_DOLLAR, 1'b1, 10'd1023, 1, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd0,    1, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd1,    1, ST_BAD_READ, 10'd0},
        '{ACT_LOAD, CH_G, 1'b0, 10'd0,     1, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd0,    1, ST_BAD_READ, 10'd0},
        '{ACT_LOAD, CH_A, 1'b0, 10'd1023,  1, ST_OK, 10'd0},
        '{ACT_LOAD, CH_C, 1'b0, 10'd0,     1, ST_OK, 10'd0},
        '{ACT_LOAD, 8'hFF, 1'b0, 10'd0,    1, ST_OK, 10'd0},
        '{ACT_LOAD, 8'h00, 1'b0, 10'd0,    1, ST_OK, 10'd0},
        '{ACT_LOAD, CH_A, 1'b0, 10'd0,     1, ST_OK, 10'd0},
        '{ACT_LOAD, CH_DOLLAR, 1'b1, 10'd0, 1, ST_OK, 10'd0},
        '{ACT_READ, 8'hFF, 1'b0, 10'd0,    1, ST_OK, 10'd6},
        '{ACT_READ, 8'h00, 1'b0, 10'd1,    0, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd2,    0, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd3,    0, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd4,    0, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd5,    0, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd6,    0, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd7,    1, ST_BAD_READ, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd1023, 1, ST_BAD_READ, 10'd0},
        '{ACT_LOAD, 8'h5A, 1'b1, 10'd0,    1, ST_OK, 10'd0},
        '{ACT_READ, 8'h00, 1'b0, 10'd0,    1, ST_OK, 10'd0}
    };

    function automatic logic [7:0] dna_byte();
        case ($urandom_range(9))
            0, 1:    return CH_A;
            2, 3:    return CH_C;
            4, 5:    return CH_G;
            6:       return CH_DOLLAR;
            7:       return 8'h54;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic set_phase(input int k);
        case (k % 4)
            0: begin snd_idle = 0;  rcv_idle = 0;  end
            1: begin snd_idle = 64; rcv_idle = 0;  end
            2: begin snd_idle = 0;  rcv_idle = 64; end
            default: begin snd_idle = 30; rcv_idle = 30; end
        endcase
    endtask

    initial begin
        int sent;
        int n;
        int k;
        int reads;
        int wait_cycles;
        logic [9:0] r;
        errors = 0;
        results_seen = 0;
        builds_done = 0;
        cycles = 0;
        pr_len = 0;
        pr_built = 1'b0;
        snd_idle = 0;
        rcv_idle = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i])
            send_item(rows[i].act, rows[i].sym, rows[i].lst, rows[i].idx,
                      rows[i].typed, rows[i].st, rows[i].start);

        // Fill the store, then overflow it twice; the second drop is flagged
        // last, so construction runs on the full text.
        set_phase(3);
        for (k = 0; k < TEXT_MAX; k++)
            send_item(ACT_LOAD, dna_byte(), 1'b0, 10'($urandom_range(1023)), 0, 0, 0);
        send_item(ACT_LOAD, dna_byte(), 1'b0, 10'd0, 0, 0, 0);
        send_item(ACT_LOAD, dna_byte(), 1'b1, 10'd0, 0, 0, 0);
        send_item(ACT_READ, 8'h00, 1'b0, 10'd1023, 0, 0, 0);
        send_item(ACT_READ, 8'hFF, 1'b0, 10'd0, 0, 0, 0);
        for (k = 0; k < 6; k++)
            send_item(ACT_READ, 8'($urandom_range(255)), 1'b0,
                      10'($urandom_range(1023)), 0, 0, 0);

        sent = 0;
        while (sent < RAND_ITEMS) begin
            set_phase(sent / 25);
            if ($urandom_range(99) < 85) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(25, 64)
                                             : $urandom_range(1, 16);
                for (k = 0; k < n; k++)
                    send_item(ACT_LOAD,
                              (k == n - 1 && $urandom_range(1)) ? CH_DOLLAR : dna_byte(),
                              k == n - 1, 10'($urandom_range(1023)), 0, 0, 0);
                reads = $urandom_range(1, n + 3);
                for (k = 0; k < reads; k++) begin
                    r = ($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                                 : 10'($urandom_range(n));
                    send_item(ACT_READ, 8'($urandom_range(255)), 1'b0, r, 0, 0, 0);
                end
                sent += n + reads;
            end else begin
                if ($urandom_range(1))
                    send_item(ACT_LOAD, dna_byte(), 1'b0, 10'($urandom_range(1023)), 0, 0, 0);
                send_item(ACT_READ, 8'($urandom_range(255)), $urandom_range(1),
                          10'($urandom_range(1023)), 0, 0, 0);
                sent += 2;
            end
        end
        s_tvalid <= 1'b0;

        rcv_idle = 0;
        wait_cycles = 0;
        while (want_status.size() != 0 && wait_cycles < 1_000_000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (50) @(posedge aclk);

        $display("Covered %0d results over %0d constructions, including a full store",
                 results_seen, builds_done);
        $display("with dropped loads and out-of-range reads, under four idling mixes.");
        if (errors == 0 && want_status.size() == 0) begin
            $display("PASS suffix_array_prefix_doubling");
        end else begin
            $display("FAIL suffix_array_prefix_doubling");
        end
        $finish;
    end

endmodule
